// ----- rtl/matrix_block_byte_encoder_assert.svh -----
// Assertion macros shared by the checker of the matrix block byte encoder.
`ifndef MATRIX_BLOCK_BYTE_ENCODER_ASSERT_SVH
`define MATRIX_BLOCK_BYTE_ENCODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MBE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mbe assertion failed");

// Next-cycle implication, checked outside reset.
`define MBE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mbe assertion failed");

`endif

// ----- rtl/mbe_pkg.sv -----
// Types and constants of the matrix block byte encoder.
`default_nettype none
package mbe_pkg;
    localparam int KEY_SIZE    = 3;
    localparam int BYTE_W      = 8;
    localparam int ENTRY_W     = 16;
    localparam int PROD_W      = ENTRY_W + BYTE_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int VALUE_W     = 25;
    localparam int ROW_W       = 2;
    localparam int COL_W       = 16;
    localparam int REG_W       = KEY_SIZE * ENTRY_W;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_ZERO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_ONE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_TWO  = 2'd2;

    typedef logic signed [BYTE_W-1:0]  msg_byte_t;
    typedef logic signed [ENTRY_W-1:0] key_entry_t;
    typedef key_entry_t [KEY_SIZE-1:0] key_row_t;
    typedef key_row_t [KEY_SIZE-1:0]   key_matrix_t;
    typedef msg_byte_t [KEY_SIZE-1:0]  column_bytes_t;

    typedef struct packed {
        logic signed [BYTE_W-1:0] message_byte;
        logic                     has_byte;
        logic                     end_of_message;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] product_value;
        logic [ROW_W-1:0]          row_index;
        logic [COL_W-1:0]          column_index;
        logic                      last_of_column;
        logic                      last_of_message;
    } out_item_t;

    // one column handed from the gatherer to the multiply stage
    typedef struct packed {
        column_bytes_t    bytes;
        logic [COL_W-1:0] column;
        logic             final_col;  // this column closes the message
        logic             tail_zero;  // an all-zero final column follows
    } column_job_t;
endpackage
`default_nettype wire

// ----- rtl/matrix_block_byte_encoder.sv -----
// Matrix block byte encoder: 3x3 key matrix times columns of signed message bytes.
// Accepts one message item per cycle while the column queue has room. Every third byte,
// and every end marker, closes a column; each column yields three results, one per key
// row, issued one per cycle while m_ready allows, through a shared multiply-add pipeline
// (three 16x8 products, then one adder into the output register), so the sustained rate
// is one result per cycle and one byte per cycle. A byte that both completes a column
// and ends the message yields six results: that column and an all-zero final column.
// Key rows must be written through the cfg port while no message is in flight; the block
// does not enforce this. cfg_ready is always high and indexes past the third key row are
// ignored. The key resets to the identity matrix.
`default_nettype none
module matrix_block_byte_encoder (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire mbe_pkg::in_item_t               s_item,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output mbe_pkg::out_item_t                   m_item,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [mbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mbe_pkg::REG_W-1:0]       cfg_data
);
    mbe_pkg::key_matrix_t  key_reg;
    logic                  push;
    mbe_pkg::column_job_t  push_job;
    logic                  queue_ready;
    logic                  pop;
    logic                  head_valid;
    mbe_pkg::column_job_t  head_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < mbe_pkg::KEY_SIZE; r++) begin
                for (int c = 0; c < mbe_pkg::KEY_SIZE; c++) begin
                    key_reg[r][c] <= (r == c) ? mbe_pkg::ENTRY_W'(1) : '0;
                end
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                mbe_pkg::REG_KEY_ROW_ZERO: key_reg[0] <= cfg_data;
                mbe_pkg::REG_KEY_ROW_ONE:  key_reg[1] <= cfg_data;
                mbe_pkg::REG_KEY_ROW_TWO:  key_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    mbe_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .push        (push),
        .push_job    (push_job),
        .queue_ready (queue_ready)
    );

    mbe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .push_ready (queue_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    mbe_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .key_matrix (key_reg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );
endmodule
`default_nettype wire

// ----- rtl/mbe_front.sv -----
// Byte gatherer: builds message columns and classifies column requests.
`default_nettype none
module mbe_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire mbe_pkg::in_item_t    s_item,
    output logic                      push,
    output mbe_pkg::column_job_t      push_job,
    input  wire logic                 queue_ready
);
    mbe_pkg::column_bytes_t          bytes_reg, bytes_next, bytes_new;
    logic [mbe_pkg::ROW_W-1:0]       fill_reg, fill_next;
    logic [mbe_pkg::COL_W-1:0]       col_reg, col_next;
    logic                            accept;
    logic                            complete;

    assign s_ready = queue_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        bytes_new = bytes_reg;
        if (s_item.has_byte) begin
            bytes_new[fill_reg] = s_item.message_byte;
        end
        complete = s_item.has_byte && (fill_reg == mbe_pkg::ROW_W'(mbe_pkg::KEY_SIZE - 1));
        push     = accept && (complete || s_item.end_of_message);

        push_job.bytes     = bytes_new;
        push_job.column    = col_reg;
        push_job.final_col = s_item.end_of_message && !complete;
        push_job.tail_zero = s_item.end_of_message && complete;

        bytes_next = bytes_reg;
        fill_next  = fill_reg;
        col_next   = col_reg;
        if (push) begin
            // slots past the fill point are always zero, so a partial column is padded
            bytes_next = '0;
            fill_next  = '0;
            col_next   = s_item.end_of_message ? '0 : col_reg + 1'b1;
        end else if (accept) begin
            bytes_next = bytes_new;
            fill_next  = fill_reg + mbe_pkg::ROW_W'(s_item.has_byte);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_reg <= '0;
            fill_reg  <= '0;
            col_reg   <= '0;
        end else begin
            bytes_reg <= bytes_next;
            fill_reg  <= fill_next;
            col_reg   <= col_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/mbe_queue.sv -----
// Short column request queue between the gatherer and the multiply stage.
`default_nettype none
module mbe_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire mbe_pkg::column_job_t push_job,
    output logic                      push_ready,
    input  wire logic                 pop,
    output logic                      head_valid,
    output mbe_pkg::column_job_t      head_job
);
    mbe_pkg::column_job_t                 entry_reg [mbe_pkg::QUEUE_DEPTH];
    logic [mbe_pkg::QUEUE_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [mbe_pkg::QUEUE_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [mbe_pkg::QUEUE_CNT_W-1:0]      count_reg, count_next;

    assign push_ready = (count_reg != mbe_pkg::QUEUE_CNT_W'(mbe_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == mbe_pkg::QUEUE_PTR_W'(mbe_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == mbe_pkg::QUEUE_PTR_W'(mbe_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/mbe_back.sv -----
// Row sequencer and two-stage multiply-add pipeline whose second stage is the output register.
`default_nettype none
module mbe_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire mbe_pkg::key_matrix_t key_matrix,
    input  wire logic                 head_valid,
    input  wire mbe_pkg::column_job_t head_job,
    output logic                      pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output mbe_pkg::out_item_t        m_item
);
    typedef logic signed [mbe_pkg::PROD_W-1:0] prod_t;

    typedef struct packed {
        prod_t [mbe_pkg::KEY_SIZE-1:0] products;
        logic [mbe_pkg::ROW_W-1:0]     row;
        logic [mbe_pkg::COL_W-1:0]     column;
        logic                          last_col;
        logic                          last_msg;
    } mul_stage_t;

    logic [mbe_pkg::ROW_W-1:0]     row_reg, row_next;
    logic                          tail_reg, tail_next;
    logic                          s1_valid_reg, s1_valid_next;
    mul_stage_t                    s1_reg, s1_next;
    logic                          out_valid_reg, out_valid_next;
    mbe_pkg::out_item_t            out_reg, out_next;
    logic                          advance;
    logic                          issue;
    logic                          last_row;
    mbe_pkg::column_bytes_t        bytes_sel;
    logic signed [mbe_pkg::SUM_W-1:0] sum;

    assign advance  = !out_valid_reg || m_ready;
    assign issue    = head_valid && advance;
    assign last_row = (row_reg == mbe_pkg::ROW_W'(mbe_pkg::KEY_SIZE - 1));
    assign pop      = issue && last_row && (tail_reg || !head_job.tail_zero);
    assign m_valid  = out_valid_reg;
    assign m_item   = out_reg;

    always_comb begin
        // the tail column after a completed final column is all zero
        bytes_sel = tail_reg ? '0 : head_job.bytes;
        for (int c = 0; c < mbe_pkg::KEY_SIZE; c++) begin
            s1_next.products[c] = key_matrix[row_reg][c] * bytes_sel[c];
        end
        s1_next.row      = row_reg;
        s1_next.column   = tail_reg ? head_job.column + 1'b1 : head_job.column;
        s1_next.last_col = last_row;
        s1_next.last_msg = last_row && (tail_reg || head_job.final_col);

        row_next  = row_reg;
        tail_next = tail_reg;
        if (issue) begin
            row_next = last_row ? '0 : row_reg + 1'b1;
            if (last_row) begin
                tail_next = !tail_reg && head_job.tail_zero;
            end
        end
        s1_valid_next = advance ? issue : s1_valid_reg;

        sum = '0;
        for (int c = 0; c < mbe_pkg::KEY_SIZE; c++) begin
            sum = sum + mbe_pkg::SUM_W'(s1_reg.products[c]);
        end
        out_next.product_value   = sum[mbe_pkg::VALUE_W-1:0];
        out_next.row_index       = s1_reg.row;
        out_next.column_index    = s1_reg.column;
        out_next.last_of_column  = s1_reg.last_col;
        out_next.last_of_message = s1_reg.last_msg;
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_reg <= s1_next;
        end
        if (advance && s1_valid_reg) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg       <= '0;
            tail_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            row_reg       <= row_next;
            tail_reg      <= tail_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/mbe_checker.sv -----
// Port-level checker for the matrix block byte encoder, bound to the top level.
`default_nettype none
`include "matrix_block_byte_encoder_assert.svh"
module mbe_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire mbe_pkg::out_item_t m_item
);
    `MBE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item))
    `MBE_ASSERT_NOW(a_last_col_row, aclk, aresetn, m_valid && m_item.last_of_column, m_item.row_index == 2'd2)
    `MBE_ASSERT_NOW(a_mid_row, aclk, aresetn, m_valid && !m_item.last_of_column, m_item.row_index != 2'd2)
    `MBE_ASSERT_NOW(a_last_msg, aclk, aresetn, m_valid && m_item.last_of_message, m_item.last_of_column)
endmodule

bind matrix_block_byte_encoder mbe_checker u_mbe_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
`default_nettype wire
